// ===== src/two_level_page_table_mapper_core_macros.svh =====
// Assertion helpers for the mapper RTL.
`ifndef TWO_LEVEL_PAGE_TABLE_MAPPER_CORE_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MAPPER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define TLPTM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define TLPTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tlptm_pkg.sv =====
package tlptm_pkg;

  localparam int ENTRIES_PER_TABLE = 1024;
  localparam int ENTRY_IDX_W       = $clog2(ENTRIES_PER_TABLE);
  localparam int DIR_DEPTH         = 1024;
  localparam int DIR_IDX_W         = $clog2(DIR_DEPTH);

  localparam logic [31:0] PG_PRESENT = 32'h0000_0001;
  localparam logic [31:0] PG_WRITE   = 32'h0000_0002;
  localparam logic [31:0] PG_USER    = 32'h0000_0004;
  localparam logic [31:0] PG_ADDR    = 32'hFFFF_F000;
  localparam logic [31:0] PG_SIZE    = 32'h0000_1000;
  localparam logic [31:0] PG_OFFSET  = 32'h0000_0FFF;
  localparam logic [31:0] VIRT_LIMIT = 32'hC000_0000;

  localparam logic [31:0] RST_USER_VIRT_BASE = 32'h4000_0000;
  localparam logic [31:0] RST_FRAME_BASE     = 32'h0100_0000;
  localparam logic [31:0] RST_POOL_BASE      = 32'h0000_A000;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_ALLOC = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_USER_VIRT_BASE = 2'd0,
    REG_FRAME_BASE     = 2'd1,
    REG_POOL_BASE      = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_t;

  // Register writes that also reload the bump pointers
  typedef struct packed {
    logic        load_virt;
    logic        load_frame;
    logic [31:0] value;
  } cfg_load_t;

endpackage

// ===== src/tlptm_ram.sv =====
module tlptm_ram #(
  parameter int DW    = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // One write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tlptm_ctrl.sv =====
`include "two_level_page_table_mapper_core_macros.svh"

module tlptm_ctrl
  import tlptm_pkg::*;
#(
  parameter int TABLE_COUNT   = 64,
  parameter int MAX_RUN_PAGES = 256,
  parameter int SLOT_W        = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1,
  parameter int POOL_AW       = SLOT_W + ENTRY_IDX_W
) (
  input  logic                 clk,
  input  logic                 rst,
  // request side
  input  logic                 in_valid,
  output logic                 in_ready,
  input  opcode_t              in_op,
  input  logic [31:0]          in_va,
  input  logic [31:0]          in_pa,
  input  logic                 in_w,
  input  logic                 in_u,
  input  logic [9:0]           in_n,
  // result side
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_status,
  output logic [31:0]          out_addr,
  // configuration
  input  cfg_load_t            cfg_load,
  input  logic [31:0]          pool_base,
  // directory memory
  output logic                 dir_we,
  output logic [DIR_IDX_W-1:0] dir_waddr,
  output logic [31:0]          dir_wdata,
  output logic [DIR_IDX_W-1:0] dir_raddr,
  input  logic [31:0]          dir_rdata,
  // table pool memory
  output logic                 pool_we,
  output logic [POOL_AW-1:0]   pool_waddr,
  output logic [31:0]          pool_wdata,
  output logic [POOL_AW-1:0]   pool_raddr,
  input  logic [31:0]          pool_rdata
);

  localparam int TU_W  = $clog2(TABLE_COUNT + 1);
  localparam int CNT_W = $clog2(MAX_RUN_PAGES + 1);

  typedef enum logic [8:0] {
    S_INIT = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_ACHK = 9'b000000100,
    S_DRD  = 9'b000001000,
    S_DCHK = 9'b000010000,
    S_ZERO = 9'b000100000,
    S_PRD  = 9'b001000000,
    S_PCHK = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t                 state, state_next;
  logic [TU_W-1:0]        tables_used, tables_used_next;
  logic [31:0]            next_virt, next_virt_next;
  logic [31:0]            frame_ptr, frame_ptr_next;
  opcode_t                op_q, op_q_next;
  logic [31:0]            va_q, va_q_next;
  logic [31:0]            pa_q, pa_q_next;
  logic [2:0]             flags_q, flags_q_next;
  logic [9:0]             n_q, n_q_next;
  logic [CNT_W-1:0]       cnt_q, cnt_q_next;
  logic [31:0]            start_q, start_q_next;
  logic                   walk_clear, walk_clear_next;
  logic [SLOT_W-1:0]      slot_q, slot_q_next;
  logic [ENTRY_IDX_W-1:0] zcnt, zcnt_next;
  logic [DIR_IDX_W-1:0]   init_cnt, init_cnt_next;
  logic                   res_status, res_status_next;
  logic [31:0]            res_addr, res_addr_next;

  logic                   end_map, end_clear, map_fail;
  logic [31:0]            flags32, base_pg, dir_off, new_dir;
  logic [19:0]            dir_idx;
  logic                   present, slot_ok, pool_full, new_table;
  logic [ENTRY_IDX_W-1:0] ti;
  logic [31:0]            run_bytes;
  logic [10:0]            cnt_inc;

  assign in_ready  = (state == S_IDLE);
  assign ti        = va_q[21:12];
  assign flags32   = {29'd0, flags_q};
  assign base_pg   = pool_base & PG_ADDR;
  assign present   = dir_rdata[0];
  assign dir_off   = (dir_rdata & PG_ADDR) - base_pg;
  assign dir_idx   = dir_off[31:12];
  assign slot_ok   = (dir_idx < 20'(tables_used)) && (dir_idx < 20'(TABLE_COUNT));
  assign pool_full = (32'(tables_used) >= 32'(TABLE_COUNT));
  assign new_dir   = ((base_pg + (32'(tables_used) << 12)) & PG_ADDR) | flags32;
  assign new_table = (state == S_DCHK) && !walk_clear && !present && !pool_full;
  assign run_bytes = {10'd0, n_q, 12'd0};
  assign cnt_inc   = 11'(cnt_q) + 11'd1;

  // Memory read addresses follow the current page
  assign dir_raddr  = va_q[31:22];
  assign pool_raddr = {slot_q, ti};

  // Sequencer
  always_comb begin
    state_next       = state;
    tables_used_next = tables_used;
    next_virt_next   = next_virt;
    frame_ptr_next   = frame_ptr;
    op_q_next        = op_q;
    va_q_next        = va_q;
    pa_q_next        = pa_q;
    flags_q_next     = flags_q;
    n_q_next         = n_q;
    cnt_q_next       = cnt_q;
    start_q_next     = start_q;
    walk_clear_next  = walk_clear;
    slot_q_next      = slot_q;
    zcnt_next        = zcnt;
    init_cnt_next    = init_cnt;
    res_status_next  = res_status;
    res_addr_next    = res_addr;
    end_map          = 1'b0;
    end_clear        = 1'b0;
    map_fail         = 1'b0;
    dir_we           = 1'b0;
    dir_waddr        = va_q[31:22];
    dir_wdata        = dir_rdata | flags32;
    pool_we          = 1'b0;
    pool_waddr       = {slot_q, ti};
    pool_wdata       = pa_q | flags32;

    case (state)
      S_INIT: begin
        dir_we        = 1'b1;
        dir_waddr     = init_cnt;
        dir_wdata     = '0;
        init_cnt_next = init_cnt + 1'b1;
        if (init_cnt == DIR_IDX_W'(DIR_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_q_next       = in_op;
          va_q_next       = in_va;
          pa_q_next       = in_pa;
          flags_q_next    = {in_u, in_w, 1'b1};
          n_q_next        = in_n;
          cnt_q_next      = '0;
          walk_clear_next = (in_op == OP_CLEAR);
          res_status_next = 1'b1;
          res_addr_next   = '0;
          case (in_op)
            OP_MAP, OP_CLEAR: state_next = S_DRD;
            OP_ALLOC:         state_next = S_ACHK;
            default:          state_next = S_DONE;
          endcase
        end
      end
      S_ACHK: begin
        va_q_next    = next_virt;
        pa_q_next    = frame_ptr;
        start_q_next = next_virt;
        flags_q_next = 3'b111;
        if (n_q == 10'd0 || 11'(n_q) > 11'(MAX_RUN_PAGES) ||
            next_virt > VIRT_LIMIT - run_bytes) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DRD;
        end
      end
      S_DRD: begin
        if (!walk_clear && ((va_q | pa_q) & PG_OFFSET) != 32'd0) begin
          end_map  = 1'b1;
          map_fail = 1'b1;
        end else begin
          state_next = S_DCHK;
        end
      end
      S_DCHK: begin
        if (walk_clear) begin
          // clear: zero the page entry when the table is live
          if (present && slot_ok) begin
            pool_we    = 1'b1;
            pool_waddr = {dir_idx[SLOT_W-1:0], ti};
            pool_wdata = '0;
          end
          end_clear = 1'b1;
        end else if (!present) begin
          if (pool_full) begin
            end_map  = 1'b1;
            map_fail = 1'b1;
          end else begin
            dir_we           = 1'b1;
            dir_wdata        = new_dir;
            tables_used_next = tables_used + 1'b1;
            slot_q_next      = tables_used[SLOT_W-1:0];
            zcnt_next        = '0;
            state_next       = S_ZERO;
          end
        end else begin
          dir_we = 1'b1;
          if (!slot_ok) begin
            end_map  = 1'b1;
            map_fail = 1'b1;
          end else begin
            slot_q_next = dir_idx[SLOT_W-1:0];
            state_next  = S_PRD;
          end
        end
      end
      S_ZERO: begin
        // sweep the fresh table, dropping the new entry in on the way
        pool_we    = 1'b1;
        pool_waddr = {slot_q, zcnt};
        pool_wdata = (zcnt == ti) ? (pa_q | flags32) : 32'd0;
        zcnt_next  = zcnt + 1'b1;
        if (zcnt == ENTRY_IDX_W'(ENTRIES_PER_TABLE - 1)) begin
          end_map = 1'b1;
        end
      end
      S_PRD: begin
        state_next = S_PCHK;
      end
      S_PCHK: begin
        if (pool_rdata[0]) begin
          map_fail = 1'b1;
        end else begin
          pool_we = 1'b1;
        end
        end_map = 1'b1;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // End of a map walk
    if (end_map) begin
      if (op_q != OP_ALLOC) begin
        res_status_next = map_fail;
        res_addr_next   = '0;
        state_next      = S_DONE;
      end else if (map_fail) begin
        res_status_next = 1'b1;
        res_addr_next   = '0;
        if (cnt_q == '0) begin
          state_next = S_DONE;
        end else begin
          cnt_q_next      = cnt_q - 1'b1;
          va_q_next       = va_q - PG_SIZE;
          walk_clear_next = 1'b1;
          state_next      = S_DRD;
        end
      end else begin
        cnt_q_next = CNT_W'(cnt_inc);
        va_q_next  = va_q + PG_SIZE;
        pa_q_next  = pa_q + PG_SIZE;
        if (cnt_inc == 11'(n_q)) begin
          next_virt_next  = va_q + PG_SIZE;
          frame_ptr_next  = pa_q + PG_SIZE;
          res_status_next = 1'b0;
          res_addr_next   = start_q;
          state_next      = S_DONE;
        end else begin
          state_next = S_DRD;
        end
      end
    end

    // End of a clear walk, either a request or a rollback step
    if (end_clear) begin
      if (op_q == OP_CLEAR) begin
        res_status_next = 1'b0;
        res_addr_next   = '0;
        state_next      = S_DONE;
      end else if (cnt_q == '0) begin
        state_next = S_DONE;
      end else begin
        cnt_q_next = cnt_q - 1'b1;
        va_q_next  = va_q - PG_SIZE;
        state_next = S_DRD;
      end
    end

    // Register writes reload the bump pointers
    if (cfg_load.load_virt) begin
      next_virt_next = cfg_load.value;
    end
    if (cfg_load.load_frame) begin
      frame_ptr_next = cfg_load.value;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      tables_used <= '0;
      next_virt   <= RST_USER_VIRT_BASE;
      frame_ptr   <= RST_FRAME_BASE;
      init_cnt    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      tables_used <= tables_used_next;
      next_virt   <= next_virt_next;
      frame_ptr   <= frame_ptr_next;
      init_cnt    <= init_cnt_next;
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and result holding register
  always_ff @(posedge clk) begin
    op_q       <= op_q_next;
    va_q       <= va_q_next;
    pa_q       <= pa_q_next;
    flags_q    <= flags_q_next;
    n_q        <= n_q_next;
    cnt_q      <= cnt_q_next;
    start_q    <= start_q_next;
    walk_clear <= walk_clear_next;
    slot_q     <= slot_q_next;
    zcnt       <= zcnt_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_status <= res_status;
      out_addr   <= res_addr;
    end
  end

  `TLPTM_ASSERT_NOW(a_pool_bound, 1'b1, 32'(tables_used) <= 32'(TABLE_COUNT), "pool overrun")
  `TLPTM_ASSERT_NOW(a_no_take_busy, state != S_IDLE, !in_ready, "request taken while busy")
  `TLPTM_ASSERT_NEXT(a_table_count, new_table, tables_used == $past(tables_used) + 1'b1, "table count slip")
  `TLPTM_ASSERT_NOW(a_zero_writes, state == S_ZERO, pool_we && !dir_we, "zero sweep stalled")
  `TLPTM_ASSERT_NEXT(a_result_load, state == S_DONE && !out_valid, out_valid, "result lost")

endmodule

// ===== src/two_level_page_table_mapper_core.sv =====
// Two-level page table mapper. Requests arrive on s_*, one result per request
// leaves on m_*. The directory (1024 words) and the table pool (TABLE_COUNT
// tables of 1024 words) live in synchronous memories with registered reads; the
// sequencer handles one request at a time. After reset the directory is swept
// to zero, during which no request is taken (register writes are). Each
// request is a read-check-write walk over the two memories: a map into an
// existing table reads and checks the directory entry, reads and checks the
// page entry, then holds the result and returns to idle; a map that takes a
// new table zeroes the whole table one word a cycle; a clear ends at the
// directory check and a map with a misaligned address before it; a run of n
// pages walks them in turn, clearing the pages already mapped on failure; a
// rejected run ends at its bounds check and opcode three goes to the result.
module two_level_page_table_mapper_core
  import tlptm_pkg::*;
#(
  parameter int TABLE_COUNT   = 64,
  parameter int MAX_RUN_PAGES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // virt_addr[31:0], phys_addr[63:32], write_ok[64],
                                // user_ok[65], run_pages[75:66], zero[79:76]
  input  logic [1:0]  s_tuser,  // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // status[0], run_address[32:1], zero[39:33]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOT_W  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int POOL_AW = SLOT_W + ENTRY_IDX_W;

  logic [31:0] user_virtual_base, frame_base, table_pool_base;
  logic        cfg_wr;
  reg_idx_t    reg_idx;
  cfg_load_t   cfg_load;

  logic                 dir_we, pool_we;
  logic [DIR_IDX_W-1:0] dir_waddr, dir_raddr;
  logic [31:0]          dir_wdata, dir_rdata, pool_wdata, pool_rdata;
  logic [POOL_AW-1:0]   pool_waddr, pool_raddr;
  logic                 out_status;
  logic [31:0]          out_addr;

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      user_virtual_base <= RST_USER_VIRT_BASE;
      frame_base        <= RST_FRAME_BASE;
      table_pool_base   <= RST_POOL_BASE;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_USER_VIRT_BASE: user_virtual_base <= pwdata;
        REG_FRAME_BASE:     frame_base        <= pwdata;
        REG_POOL_BASE:      table_pool_base   <= pwdata;
        default:            ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_USER_VIRT_BASE: prdata = user_virtual_base;
      REG_FRAME_BASE:     prdata = frame_base;
      REG_POOL_BASE:      prdata = table_pool_base;
      default:            prdata = '0;
    endcase
  end

  assign cfg_load.load_virt  = cfg_wr && (reg_idx == REG_USER_VIRT_BASE);
  assign cfg_load.load_frame = cfg_wr && (reg_idx == REG_FRAME_BASE);
  assign cfg_load.value      = pwdata;

  // Sequencer
  tlptm_ctrl #(
    .TABLE_COUNT   (TABLE_COUNT),
    .MAX_RUN_PAGES (MAX_RUN_PAGES),
    .SLOT_W        (SLOT_W),
    .POOL_AW       (POOL_AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (opcode_t'(s_tuser)),
    .in_va      (s_tdata[31:0]),
    .in_pa      (s_tdata[63:32]),
    .in_w       (s_tdata[64]),
    .in_u       (s_tdata[65]),
    .in_n       (s_tdata[75:66]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_addr   (out_addr),
    .cfg_load   (cfg_load),
    .pool_base  (table_pool_base),
    .dir_we     (dir_we),
    .dir_waddr  (dir_waddr),
    .dir_wdata  (dir_wdata),
    .dir_raddr  (dir_raddr),
    .dir_rdata  (dir_rdata),
    .pool_we    (pool_we),
    .pool_waddr (pool_waddr),
    .pool_wdata (pool_wdata),
    .pool_raddr (pool_raddr),
    .pool_rdata (pool_rdata)
  );

  assign m_tdata = {7'd0, out_addr, out_status};

  // Page directory
  tlptm_ram #(
    .DW    (32),
    .DEPTH (DIR_DEPTH),
    .AW    (DIR_IDX_W)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  // Page table pool
  tlptm_ram #(
    .DW    (32),
    .DEPTH (TABLE_COUNT * ENTRIES_PER_TABLE),
    .AW    (POOL_AW)
  ) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

endmodule
